### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks. Each macro expects signals
// named clk and rst_n in scope (rst_n active low, checks off during reset).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PNS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pns check failed");

// Next-cycle implication.
`define PNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pns check failed");

`endif

### hw/rtl/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg
// Types, sizes and helper functions shared by the packed nucleotide store.
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

  // store sizes
  localparam int STORE_BYTES   = 65536;
  localparam int MAX_SEQUENCES = 1024;
  localparam int SEQ_LEN_LIMIT = 262144;

  // field widths fixed by the interface
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ID_W     = 10;
  localparam int IDX_W    = 18;
  localparam int LEN_W    = 19;
  localparam int SCOUNT_W = 11;
  localparam int STAT_W   = 2;

  // derived widths
  localparam int BYTE_AW = $clog2(STORE_BYTES);
  localparam int ENT_AW  = $clog2(MAX_SEQUENCES);
  localparam int CNT_W   = $clog2(MAX_SEQUENCES + 1);
  localparam int START_W = $clog2(STORE_BYTES + 1);
  localparam int OFF_W   = BYTE_AW;
  localparam int ENT_W   = OFF_W + LEN_W;
  localparam int SUM_W   = ((START_W > (LEN_W - 2)) ? START_W : (LEN_W - 2)) + 1;

  // front/back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_CLOSE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_ID    = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_CLOSE,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] base_char;
    logic [ID_W-1:0]   seq_id;
    logic [IDX_W-1:0]  base_index;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   base_out;
    logic [LEN_W-1:0]    seq_length;
    logic [SCOUNT_W-1:0] stored_count;
    logic [STAT_W-1:0]   status;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t              op;
    logic [1:0]       code;
    logic [ID_W-1:0]  seq_id;
    logic [IDX_W-1:0] base_index;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ASCII letter to 2-bit base code; unknown letters map to A
  function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
    logic [1:0] c;
    begin
      case (ch)
        8'h43, 8'h63:               c = 2'd1; // C c
        8'h47, 8'h67:               c = 2'd2; // G g
        8'h54, 8'h74, 8'h55, 8'h75: c = 2'd3; // T t U u
        default:                    c = 2'd0;
      endcase
      return c;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] code_letter(input logic [1:0] code);
    logic [CHAR_W-1:0] l;
    begin
      case (code)
        2'd0:    l = 8'h41; // A
        2'd1:    l = 8'h43; // C
        2'd2:    l = 8'h47; // G
        default: l = 8'h54; // T
      endcase
      return l;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/packed_nucleotide_store.sv
// ----------------------------------------------------------------------------
// packed_nucleotide_store
// Store of DNA sequences packed two bits per base, four bases to a byte, with
// append, close and random-access read requests.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload               handshake
//   in_      in   pns_pkg::in_word_t    in_valid / in_stall (stall driven here)
//   out_     out  pns_pkg::out_word_t   out_valid / out_stall (stall from sink)
//
// Steps: an append, close, no-op or bad-id read is done by the back stage in
//   its idle state alone; a good read steps through the entry table RAM read,
//   then the byte RAM read, then the result, as the two registered RAM reads
//   lie in series; a read past the entry's end stops after the entry read.
// Path: an accepted word passes the front register, the queue and the result
//   register before its result shows.
// Reset: synchronous, active low; clears state, counters and open start/length.
//   The RAMs are not cleared; reads only reach entries already written.
// Stalls: the front keeps accepting while the two-entry queue has room; the
//   back pauses whenever the result register is held by out_stall.
//
`default_nettype none

module packed_nucleotide_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire pns_pkg::in_word_t in_word,
  output logic                   in_stall,
  output logic                   out_valid,
  output pns_pkg::out_word_t     out_word,
  input  wire logic              out_stall
);

  pns_pkg::q_stat_t q_stat;
  pns_pkg::cmd_t    push_cmd;
  pns_pkg::cmd_t    head;
  logic             push;
  logic             pop;

  // front: accept and decode
  pns_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  // decoupling queue
  pns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  // back: stores, sequence bookkeeping, result register
  pns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

### hw/rtl/pns_ram.sv
// ----------------------------------------------------------------------------
// pns_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/pns_front.sv
// ----------------------------------------------------------------------------
// pns_front
// Input stage: takes request words, decodes them into commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire pns_pkg::in_word_t in_word,
  output logic                  in_stall,
  input  wire pns_pkg::q_stat_t q_stat,
  output logic                  push,
  output pns_pkg::cmd_t         cmd
);

  logic           hold_r, hold_nxt;
  pns_pkg::cmd_t  cmd_r, cmd_nxt;
  pns_pkg::cmd_t  dec;
  logic           accept;

  // decode
  always_comb begin
    dec.code       = pns_pkg::base_code(in_word.base_char);
    dec.seq_id     = in_word.seq_id;
    dec.base_index = in_word.base_index;
    case (in_word.req_type)
      pns_pkg::REQ_APPEND: dec.op = pns_pkg::OP_APPEND;
      pns_pkg::REQ_CLOSE:  dec.op = pns_pkg::OP_CLOSE;
      pns_pkg::REQ_READ:   dec.op = pns_pkg::OP_READ;
      default:             dec.op = pns_pkg::OP_NOP;
    endcase
  end

  assign push     = hold_r && !q_stat.full;
  assign in_stall = hold_r && q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hold_nxt = hold_r;
    cmd_nxt  = cmd_r;
    if (accept) begin
      hold_nxt = 1'b1;
      cmd_nxt  = dec;
    end else if (push) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd = cmd_r;

endmodule

`default_nettype wire

### hw/rtl/pns_queue.sv
// ----------------------------------------------------------------------------
// pns_queue
// Short command FIFO decoupling the front stage from the back stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire pns_pkg::cmd_t    push_cmd,
  input  wire logic             pop,
  output pns_pkg::q_stat_t      q_stat,
  output pns_pkg::cmd_t         head
);

  pns_pkg::cmd_t                  mem_r [pns_pkg::QUEUE_DEPTH];
  logic [pns_pkg::Q_PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [pns_pkg::Q_PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [pns_pkg::Q_CW-1:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pns_pkg::Q_PW'(pns_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : pns_pkg::Q_PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pns_pkg::Q_PW'(pns_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : pns_pkg::Q_PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = pns_pkg::Q_CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = pns_pkg::Q_CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign q_stat.full  = (count_r == pns_pkg::Q_CW'(pns_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

### hw/rtl/pns_back.sv
// ----------------------------------------------------------------------------
// pns_back
// Execution stage: owns the byte store, entry table and open-sequence state,
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pns_pkg::q_stat_t q_stat,
  input  wire pns_pkg::cmd_t    head,
  output logic                  pop,
  output logic                  out_valid,
  output pns_pkg::out_word_t    out_word,
  input  wire logic             out_stall
);

  typedef enum logic [1:0] {S_IDLE, S_ENTRY, S_BYTE} state_t;

  state_t                            state_r, state_nxt;
  logic [pns_pkg::CNT_W-1:0]         ent_cnt_r, ent_cnt_nxt;
  logic [pns_pkg::START_W-1:0]       open_start_r, open_start_nxt;
  logic [pns_pkg::LEN_W-1:0]         open_len_r, open_len_nxt;
  logic [pns_pkg::CHAR_W-1:0]        open_byte_r, open_byte_nxt;
  logic [pns_pkg::IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic [pns_pkg::LEN_W-1:0]         rd_len_r, rd_len_nxt;
  logic                              out_valid_r, out_valid_nxt;
  pns_pkg::out_word_t                out_word_r, out_word_nxt;

  // RAM ports
  logic                              byte_we, byte_re;
  logic [pns_pkg::BYTE_AW-1:0]       byte_waddr, byte_raddr;
  logic [pns_pkg::CHAR_W-1:0]        byte_wdata, byte_rdata;
  logic                              ent_we, ent_re;
  logic [pns_pkg::ENT_AW-1:0]        ent_waddr, ent_raddr;
  logic [pns_pkg::ENT_W-1:0]         ent_wdata, ent_rdata;

  // datapath
  logic                              out_free;
  logic [1:0]                        app_sub;
  logic [pns_pkg::SUM_W-1:0]         app_addr;
  logic                              app_full;
  logic [pns_pkg::CHAR_W-1:0]        app_bits, app_byte;
  logic                              ent_full;
  logic [pns_pkg::LEN_W:0]           len_p3;
  logic                              bad_id;
  logic [pns_pkg::OFF_W-1:0]         e_off;
  logic [pns_pkg::LEN_W-1:0]         e_len;
  logic                              bad_idx;
  logic [pns_pkg::SUM_W-1:0]         rd_addr;
  logic [pns_pkg::CHAR_W-1:0]        rd_shift;

  pns_ram #(.WIDTH(pns_pkg::CHAR_W), .DEPTH(pns_pkg::STORE_BYTES)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .re    (byte_re),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  pns_ram #(.WIDTH(pns_pkg::ENT_W), .DEPTH(pns_pkg::MAX_SEQUENCES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  // append path: partial byte of the open sequence is kept in open_byte_r
  assign app_sub  = open_len_r[1:0];
  assign app_addr = pns_pkg::SUM_W'(open_start_r) + pns_pkg::SUM_W'(open_len_r >> 2);
  assign app_full = (open_len_r >= pns_pkg::LEN_W'(pns_pkg::SEQ_LEN_LIMIT)) ||
                    (app_addr >= pns_pkg::SUM_W'(pns_pkg::STORE_BYTES));
  assign app_bits = pns_pkg::CHAR_W'(head.code) << {app_sub, 1'b0};
  assign app_byte = (app_sub == 2'd0) ? app_bits : (open_byte_r | app_bits);

  // close path
  assign ent_full = (ent_cnt_r >= pns_pkg::CNT_W'(pns_pkg::MAX_SEQUENCES));
  assign len_p3   = (pns_pkg::LEN_W + 1)'(open_len_r) + (pns_pkg::LEN_W + 1)'(3);

  // read path
  assign bad_id   = (32'(head.seq_id) >= 32'(ent_cnt_r));
  assign e_off    = ent_rdata[pns_pkg::ENT_W-1:pns_pkg::LEN_W];
  assign e_len    = ent_rdata[pns_pkg::LEN_W-1:0];
  assign bad_idx  = (pns_pkg::LEN_W'(rd_idx_r) >= e_len);
  assign rd_addr  = pns_pkg::SUM_W'(e_off) + pns_pkg::SUM_W'(rd_idx_r >> 2);
  assign rd_shift = byte_rdata >> {rd_idx_r[1:0], 1'b0};

  always_comb begin
    state_nxt      = state_r;
    ent_cnt_nxt    = ent_cnt_r;
    open_start_nxt = open_start_r;
    open_len_nxt   = open_len_r;
    open_byte_nxt  = open_byte_r;
    rd_idx_nxt     = rd_idx_r;
    rd_len_nxt     = rd_len_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    pop            = 1'b0;

    byte_we    = 1'b0;
    byte_waddr = app_addr[pns_pkg::BYTE_AW-1:0];
    byte_wdata = app_byte;
    byte_re    = 1'b0;
    byte_raddr = (rd_addr >= pns_pkg::SUM_W'(pns_pkg::STORE_BYTES)) ?
                 '0 : rd_addr[pns_pkg::BYTE_AW-1:0];
    ent_we     = 1'b0;
    ent_waddr  = ent_cnt_r[pns_pkg::ENT_AW-1:0];
    ent_wdata  = {pns_pkg::OFF_W'(open_start_r), open_len_r};
    ent_re     = 1'b0;
    ent_raddr  = pns_pkg::ENT_AW'(head.seq_id);

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty && out_free) begin
          pop                       = 1'b1;
          out_word_nxt              = '0;
          out_word_nxt.stored_count = pns_pkg::SCOUNT_W'(ent_cnt_r);
          out_word_nxt.status       = pns_pkg::ST_OK;
          case (head.op)
            pns_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (app_full) begin
                out_word_nxt.status = pns_pkg::ST_FULL;
              end else begin
                byte_we       = 1'b1;
                open_byte_nxt = app_byte;
                open_len_nxt  = pns_pkg::LEN_W'(open_len_r + 1'b1);
              end
            end
            pns_pkg::OP_CLOSE: begin
              out_valid_nxt = 1'b1;
              if (ent_full) begin
                out_word_nxt.status = pns_pkg::ST_FULL;
              end else begin
                ent_we                    = 1'b1;
                ent_cnt_nxt               = pns_pkg::CNT_W'(ent_cnt_r + 1'b1);
                open_start_nxt            = pns_pkg::START_W'(open_start_r +
                                            pns_pkg::START_W'(len_p3 >> 2));
                open_len_nxt              = '0;
                out_word_nxt.seq_length   = open_len_r;
                out_word_nxt.stored_count = pns_pkg::SCOUNT_W'(ent_cnt_r + 1'b1);
              end
            end
            pns_pkg::OP_READ: begin
              if (bad_id) begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.status = pns_pkg::ST_BAD_ID;
              end else begin
                ent_re     = 1'b1;
                rd_idx_nxt = head.base_index;
                state_nxt  = S_ENTRY;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ENTRY: begin
        rd_len_nxt = e_len;
        if (bad_idx) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.base_out   = '0;
          out_word_nxt.seq_length = e_len;
          out_word_nxt.status     = pns_pkg::ST_BAD_INDEX;
          state_nxt               = S_IDLE;
        end else begin
          byte_re   = 1'b1;
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        out_valid_nxt           = 1'b1;
        out_word_nxt.base_out   = pns_pkg::code_letter(rd_shift[1:0]);
        out_word_nxt.seq_length = rd_len_r;
        out_word_nxt.status     = pns_pkg::ST_OK;
        state_nxt               = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ent_cnt_r    <= '0;
      open_start_r <= '0;
      open_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ent_cnt_r    <= ent_cnt_nxt;
      open_start_r <= open_start_nxt;
      open_len_r   <= open_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    open_byte_r <= open_byte_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_len_r    <= rd_len_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### hw/rtl/pns_checker.sv
// ----------------------------------------------------------------------------
// pns_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pns_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              out_valid,
  input  wire pns_pkg::out_word_t out_word,
  input  wire logic              out_stall
);

  logic is_err;
  logic is_bad_id;
  logic has_base;
  logic count_ok;
  logic letter_ok;

  assign is_err    = out_valid && (out_word.status != pns_pkg::ST_OK);
  assign is_bad_id = out_valid && (out_word.status == pns_pkg::ST_BAD_ID);
  assign has_base  = out_valid && (out_word.base_out != '0);
  assign count_ok  = (32'(out_word.stored_count) <= pns_pkg::MAX_SEQUENCES);
  assign letter_ok = (out_word.base_out == pns_pkg::code_letter(2'd0)) ||
                     (out_word.base_out == pns_pkg::code_letter(2'd1)) ||
                     (out_word.base_out == pns_pkg::code_letter(2'd2)) ||
                     (out_word.base_out == pns_pkg::code_letter(2'd3));

  `PNS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `PNS_ASSERT_SAME(a_err_no_base, is_err, out_word.base_out == '0)
  `PNS_ASSERT_SAME(a_bad_id_len, is_bad_id, out_word.seq_length == '0)
  `PNS_ASSERT_SAME(a_count_max, out_valid, count_ok)
  `PNS_ASSERT_SAME(a_letter, has_base, letter_ok)

endmodule

bind packed_nucleotide_store pns_checker u_pns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_word  (out_word),
  .out_stall (out_stall)
);

`default_nettype wire
